FILE: sv/csss_pkg.sv
// Shared types and constants for the clocked serial sensor slave.
package csss_pkg;

    localparam int unsigned FRAME_W   = 29;
    localparam int unsigned BEAT_W    = 5;
    localparam int unsigned RUN_W     = 3;
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned COLOUR_W  = 24;
    localparam int unsigned SAMPLE_W  = 10;

    localparam logic [BEAT_W-1:0] CAPS_LAST = BEAT_W'(28);
    localparam logic [BEAT_W-1:0] DATA_LAST = BEAT_W'(17);
    localparam logic [BEAT_W-1:0] CMD_BEATS = BEAT_W'(2);
    localparam logic [BEAT_W-1:0] RGB_BEATS = BEAT_W'(24);
    localparam logic [RUN_W-1:0]  SYNC_LOWS = RUN_W'(4);

    // Capability frame: 21, nibbles 2 2 4 4 1, then a trailing one.
    localparam logic [FRAME_W-1:0] CAPS_WORD =
        {8'd21, 4'd2, 4'd2, 4'd4, 4'd4, 4'd1, 1'b1};
    localparam logic [7:0] DATA_HDR = 8'h0A;

    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_A = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET_B = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    localparam logic REQ_EDGE   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_TX   = 5'b00010,
        PH_SYNC = 5'b00100,
        PH_CMD  = 5'b01000,
        PH_RGB  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic       req_type;
        logic       data_in;
        logic [3:0] sample_x;
        logic [3:0] sample_y;
        logic       sample_btn_a;
        logic       sample_btn_b;
    } t_item;

    typedef struct packed {
        logic       line_out;
        logic       line_drive;
        logic       busy_res;
        logic       colour_valid;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_result;

endpackage

FILE: sv/csss_engine.sv
// Link state machine: protocol state registers and the per-item update.
module csss_engine
    import csss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_en,
    input  t_item   i_item,
    output t_result o_result
);

    t_phase                r_phase,       n_phase;
    logic [BEAT_W-1:0]     r_beat,        n_beat;
    logic                  r_caps_done,   n_caps_done;
    logic                  r_force,       n_force;
    logic                  r_ready,       n_ready;
    logic [FRAME_W-1:0]    r_tx_frame,    n_tx_frame;
    logic [RUN_W-1:0]      r_low_run,     n_low_run;
    logic [CMD_W-1:0]      r_cmd,         n_cmd;
    logic [COLOUR_W-1:0]   r_rx_shift,    n_rx_shift;
    logic [COLOUR_W-1:0]   r_colour,      n_colour;
    logic [SAMPLE_W-1:0]   r_cache,       n_cache;

    logic [SAMPLE_W-1:0]   sample;
    logic [31:0]           frame_ext;
    logic                  colour_valid;

    assign sample = {i_item.sample_btn_b, i_item.sample_btn_a,
                     i_item.sample_y, i_item.sample_x};

    always_comb begin
        n_phase     = r_phase;
        n_beat      = r_beat;
        n_caps_done = r_caps_done;
        n_force     = r_force;
        n_ready     = r_ready;
        n_tx_frame  = r_tx_frame;
        n_low_run   = r_low_run;
        n_cmd       = r_cmd;
        n_rx_shift  = r_rx_shift;
        n_colour    = r_colour;
        n_cache     = r_cache;
        colour_valid = 1'b0;

        if (i_item.req_type == REQ_SAMPLE) begin
            if (r_force || sample != r_cache) begin
                n_cache = sample;
                n_ready = 1'b1;
                n_force = 1'b0;
            end
        end else begin
            unique case (r_phase)
                PH_TX: begin
                    if (r_beat == '0) begin
                        n_phase   = PH_SYNC;
                        n_low_run = i_item.data_in ? '0 : RUN_W'(1);
                    end else begin
                        n_beat = r_beat - BEAT_W'(1);
                    end
                end
                PH_SYNC: begin
                    n_low_run = i_item.data_in ? '0 : r_low_run + RUN_W'(1);
                    if (n_low_run >= SYNC_LOWS) begin
                        n_low_run = '0;
                        n_phase   = PH_CMD;
                        n_beat    = '0;
                        n_cmd     = '0;
                    end
                end
                PH_CMD: begin
                    n_cmd  = {r_cmd[0], i_item.data_in};
                    n_beat = r_beat + BEAT_W'(1);
                    if (n_beat >= CMD_BEATS) begin
                        if (n_cmd == CMD_SET_A || n_cmd == CMD_SET_B) begin
                            n_phase    = PH_RGB;
                            n_beat     = '0;
                            n_rx_shift = '0;
                        end else begin
                            if (n_cmd == CMD_CLEAR) begin
                                n_colour     = '0;
                                colour_valid = 1'b1;
                            end
                            n_phase = PH_IDLE;
                            n_beat  = '0;
                        end
                    end
                end
                PH_RGB: begin
                    n_rx_shift = {r_rx_shift[COLOUR_W-2:0], i_item.data_in};
                    n_beat     = r_beat + BEAT_W'(1);
                    if (n_beat >= RGB_BEATS) begin
                        n_colour     = n_rx_shift;
                        colour_valid = 1'b1;
                        n_phase      = PH_IDLE;
                        n_beat       = '0;
                    end
                end
                default: begin
                    // idle (and any stray code): any edge opens an exchange
                    n_ready = 1'b0;
                    if (!r_caps_done) begin
                        n_tx_frame  = CAPS_WORD;
                        n_beat      = CAPS_LAST;
                        n_caps_done = 1'b1;
                        n_force     = 1'b1;
                    end else begin
                        n_tx_frame = FRAME_W'({DATA_HDR, r_cache[3:0], r_cache[7:4],
                                               r_cache[8], r_cache[9]});
                        n_beat     = DATA_LAST;
                    end
                    n_phase = PH_TX;
                end
            endcase
        end
    end

    assign frame_ext = {{(32 - FRAME_W){1'b0}}, n_tx_frame};

    // Line outputs reflect the state after this item.
    always_comb begin
        o_result.colour_valid = colour_valid;
        o_result.red          = n_colour[23:16];
        o_result.green        = n_colour[15:8];
        o_result.blue         = n_colour[7:0];
        priority if (n_phase == PH_TX) begin
            o_result.line_out   = frame_ext[n_beat];
            o_result.line_drive = 1'b1;
            o_result.busy_res   = 1'b1;
        end else if (n_phase == PH_SYNC || n_phase == PH_CMD || n_phase == PH_RGB) begin
            o_result.line_out   = 1'b0;
            o_result.line_drive = 1'b0;
            o_result.busy_res   = 1'b1;
        end else begin
            o_result.line_out   = n_ready;
            o_result.line_drive = 1'b1;
            o_result.busy_res   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_beat      <= '0;
            r_caps_done <= 1'b0;
            r_force     <= 1'b0;
            r_ready     <= 1'b0;
            r_tx_frame  <= '0;
            r_low_run   <= '0;
            r_cmd       <= '0;
            r_rx_shift  <= '0;
            r_colour    <= '0;
            r_cache     <= '0;
        end else if (i_item_en) begin
            r_phase     <= n_phase;
            r_beat      <= n_beat;
            r_caps_done <= n_caps_done;
            r_force     <= n_force;
            r_ready     <= n_ready;
            r_tx_frame  <= n_tx_frame;
            r_low_run   <= n_low_run;
            r_cmd       <= n_cmd;
            r_rx_shift  <= n_rx_shift;
            r_colour    <= n_colour;
            r_cache     <= n_cache;
        end
    end

endmodule

FILE: sv/clocked_serial_sensor_slave_core.sv
// The link state updates as an item leaves the input register into the result register.
// Throughput: one item per cycle while the output is not stalled.
// A stalled output holds the result register and, through it, the input register.
// Reset (i_rst_n low, synchronous) empties both registers and returns the link to idle,
// capabilities unsent, colour zero, sample cache zero.
module clocked_serial_sensor_slave_core
    import csss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_req_type,
    input  logic       i_data_in,
    input  logic [3:0] i_sample_x,
    input  logic [3:0] i_sample_y,
    input  logic       i_sample_btn_a,
    input  logic       i_sample_btn_b,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_line_out,
    output logic       o_line_drive,
    output logic       o_busy_res,
    output logic       o_colour_valid,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result step_result;
    logic    advance;

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    csss_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item_en (r_in_valid && advance),
        .i_item    (r_item),
        .o_result  (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= '{req_type:     i_req_type,
                        data_in:      i_data_in,
                        sample_x:     i_sample_x,
                        sample_y:     i_sample_y,
                        sample_btn_a: i_sample_btn_a,
                        sample_btn_b: i_sample_btn_b};
        end
        if (r_in_valid && advance) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_line_out     = r_result.line_out;
    assign o_line_drive   = r_result.line_drive;
    assign o_busy_res     = r_result.busy_res;
    assign o_colour_valid = r_result.colour_valid;
    assign o_red          = r_result.red;
    assign o_green        = r_result.green;
    assign o_blue         = r_result.blue;

endmodule

FILE: sv/csss_checker.sv
// Port-level checks for the serial sensor slave, bound to the top level.
module csss_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_line_out,
    input logic       o_line_drive,
    input logic       o_busy_res,
    input logic       o_colour_valid,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_red)
            && $stable(o_green) && $stable(o_blue) && $stable(o_busy_res))
        else $error("result changed while stalled");

    // A colour update ends the exchange: idle and driving again.
    a_colour_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_colour_valid |-> !o_busy_res && o_line_drive)
        else $error("colour update without end of exchange");

    // Released line only happens mid-exchange, and then reads low.
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_line_drive |-> o_busy_res && !o_line_out)
        else $error("line released outside an exchange");

    // Nothing is presented right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind clocked_serial_sensor_slave_core csss_checker u_csss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_line_out     (o_line_out),
    .o_line_drive   (o_line_drive),
    .o_busy_res     (o_busy_res),
    .o_colour_valid (o_colour_valid),
    .o_red          (o_red),
    .o_green        (o_green),
    .o_blue         (o_blue)
);
